### rtl/core/ssps_pkg.sv
// shared types and constants of the spi status poll sequencer
package ssps_pkg;

   localparam int MAX_COMPARE_BYTES_DEF = 8;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int TIME_W      = 32;
   localparam int RX_W        = 64;
   localparam int CMP_LEN_W   = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_POLL_MODE        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMPARE_LENGTH   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATCH_MASK       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATCH_VALUE      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLL_INTERVAL_US = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLL_TIMEOUT_US  = 3'd5;

   localparam logic                 POLL_MODE_RST        = 1'b1;
   localparam logic [CMP_LEN_W-1:0] COMPARE_LENGTH_RST   = 4'd1;
   localparam logic [RX_W-1:0]      MATCH_MASK_RST       = 64'd0;
   localparam logic [RX_W-1:0]      MATCH_VALUE_RST      = 64'd0;
   localparam logic [TIME_W-1:0]    POLL_INTERVAL_US_RST = 32'd0;
   localparam logic [TIME_W-1:0]    POLL_TIMEOUT_US_RST  = 32'd1000000;

   typedef enum logic [1:0] {
      REQ_START    = 2'd0,
      REQ_TX_DONE  = 2'd1,
      REQ_RX_DONE  = 2'd2,
      REQ_TICK     = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ACT_NONE = 3'd0,
      ACT_TX   = 3'd1,
      ACT_RX   = 3'd2,
      ACT_OK   = 3'd3,
      ACT_ERR  = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BUS     = 2'd1,
      ST_TIMEOUT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PH_IDLE          = 3'd0,
      PH_WAIT_TX       = 3'd1,
      PH_WAIT_RX       = 3'd2,
      PH_WAIT_INTERVAL = 3'd3,
      PH_DONE          = 3'd4,
      PH_ERROR         = 3'd5
   } phase_type;

endpackage

### rtl/core/spi_status_poll_sequencer_core.sv
// Sequences an spi command transmit followed by a single receive or by status polling
// until the masked received bytes match, a timeout passes or a bus error is reported.
// Each item produces exactly one result item. An accepted item is captured in an input
// register and evaluated against the sequencer state once the output register is free; the
// state updates in that same cycle while the result lands in an output register. One item
// is accepted every cycle while the result side keeps up; a stalled result holds the input
// register and then stalls the request side.
// There is no clearing pass after reset. Time differences wrap modulo 2^32.
module spi_status_poll_sequencer_core #(
   parameter int MAX_COMPARE_BYTES = ssps_pkg::MAX_COMPARE_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_type,
   input  logic [ssps_pkg::TIME_W-1:0]        req_now_us,
   input  logic                               req_bus_error,
   input  logic [ssps_pkg::RX_W-1:0]          req_rx_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [2:0]                         rsp_action,
   output logic [1:0]                         rsp_status,
   output logic [2:0]                         rsp_phase,
   output logic                               rsp_chip_select_n,
   input  logic                               csr_we,
   input  logic [ssps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ssps_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ssps_pkg::*;

   // configuration
   logic                 poll_mode_ff;
   logic [CMP_LEN_W-1:0] compare_length_ff;
   logic [RX_W-1:0]      match_mask_ff;
   logic [RX_W-1:0]      match_value_ff;
   logic [TIME_W-1:0]    poll_interval_us_ff;
   logic [TIME_W-1:0]    poll_timeout_us_ff;

   // input register
   logic                 s1_valid_ff;
   req_kind_type         s1_type_ff;
   logic [TIME_W-1:0]    s1_now_ff;
   logic                 s1_berr_ff;
   logic [RX_W-1:0]      s1_rx_ff;

   // sequencer state
   phase_type            phase_ff,       phase_in;
   logic [TIME_W-1:0]    poll_begin_ff,  poll_begin_in;
   logic [TIME_W-1:0]    interval_start_ff, interval_start_in;
   logic                 poll_pending_ff, poll_pending_in;
   logic                 busy_ff,        busy_in;
   status_type           last_status_ff, last_status_in;
   action_type           action_in;

   // output register
   logic                 rsp_valid_ff;
   action_type           rsp_action_ff;
   status_type           rsp_status_ff;
   phase_type            rsp_phase_ff;
   logic                 rsp_cs_n_ff;

   logic                 out_free;
   logic                 s1_move;
   logic                 req_take;
   logic                 bytes_match;
   logic [TIME_W-1:0]    since_begin;
   logic [TIME_W-1:0]    since_interval;
   logic                 cs_n_in;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_mode_ff        <= POLL_MODE_RST;
         compare_length_ff   <= COMPARE_LENGTH_RST;
         match_mask_ff       <= MATCH_MASK_RST;
         match_value_ff      <= MATCH_VALUE_RST;
         poll_interval_us_ff <= POLL_INTERVAL_US_RST;
         poll_timeout_us_ff  <= POLL_TIMEOUT_US_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_POLL_MODE:        poll_mode_ff        <= csr_wdata[0];
            CSR_COMPARE_LENGTH:   compare_length_ff   <= csr_wdata[CMP_LEN_W-1:0];
            CSR_MATCH_MASK:       match_mask_ff       <= csr_wdata;
            CSR_MATCH_VALUE:      match_value_ff      <= csr_wdata;
            CSR_POLL_INTERVAL_US: poll_interval_us_ff <= csr_wdata[TIME_W-1:0];
            CSR_POLL_TIMEOUT_US:  poll_timeout_us_ff  <= csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_type_ff <= req_kind_type'(req_type);
         s1_now_ff  <= req_now_us;
         s1_berr_ff <= req_bus_error;
         s1_rx_ff   <= req_rx_data;
      end
   end

   // masked compare over the saturated byte count
   always_comb begin
      bytes_match = 1'b1;
      for (int i = 0; i < MAX_COMPARE_BYTES; i++) begin
         if (CMP_LEN_W'(i) < compare_length_ff &&
             (s1_rx_ff[i*8 +: 8] & match_mask_ff[i*8 +: 8]) != match_value_ff[i*8 +: 8]) begin
            bytes_match = 1'b0;
         end
      end
   end

   assign since_begin    = s1_now_ff - poll_begin_ff;
   assign since_interval = s1_now_ff - interval_start_ff;

   always_comb begin
      phase_in          = phase_ff;
      poll_begin_in     = poll_begin_ff;
      interval_start_in = interval_start_ff;
      poll_pending_in   = poll_pending_ff;
      busy_in           = busy_ff;
      last_status_in    = last_status_ff;
      action_in         = ACT_NONE;
      case (s1_type_ff)
         REQ_START: begin
            if (!busy_ff) begin
               poll_begin_in   = s1_now_ff;
               busy_in         = 1'b1;
               poll_pending_in = 1'b0;
               last_status_in  = ST_OK;
               phase_in        = PH_WAIT_TX;
               action_in       = ACT_TX;
            end
         end
         REQ_TX_DONE: begin
            if (phase_ff == PH_WAIT_TX) begin
               if (s1_berr_ff) begin
                  last_status_in  = ST_BUS;
                  busy_in         = 1'b0;
                  poll_pending_in = 1'b0;
                  phase_in        = PH_ERROR;
                  action_in       = ACT_ERR;
               end else begin
                  phase_in  = PH_WAIT_RX;
                  action_in = ACT_RX;
               end
            end
         end
         REQ_RX_DONE: begin
            if (phase_ff == PH_WAIT_RX) begin
               if (s1_berr_ff) begin
                  last_status_in  = ST_BUS;
                  busy_in         = 1'b0;
                  poll_pending_in = 1'b0;
                  phase_in        = PH_ERROR;
                  action_in       = ACT_ERR;
               end else if (!poll_mode_ff || bytes_match) begin
                  last_status_in  = ST_OK;
                  busy_in         = 1'b0;
                  poll_pending_in = 1'b0;
                  phase_in        = PH_DONE;
                  action_in       = ACT_OK;
               end else if (since_begin <= poll_timeout_us_ff) begin
                  if (poll_interval_us_ff == '0) begin
                     action_in = ACT_RX;
                  end else begin
                     interval_start_in = s1_now_ff;
                     poll_pending_in   = 1'b1;
                     phase_in          = PH_WAIT_INTERVAL;
                  end
               end else begin
                  last_status_in  = ST_TIMEOUT;
                  busy_in         = 1'b0;
                  poll_pending_in = 1'b0;
                  phase_in        = PH_ERROR;
                  action_in       = ACT_ERR;
               end
            end
         end
         REQ_TICK: begin
            if (phase_ff == PH_WAIT_INTERVAL && busy_ff && poll_pending_ff &&
                since_interval >= poll_interval_us_ff) begin
               poll_pending_in   = 1'b0;
               interval_start_in = s1_now_ff;
               phase_in          = PH_WAIT_RX;
               action_in         = ACT_RX;
            end
         end
         default: ;
      endcase
   end

   assign cs_n_in = !(phase_in == PH_WAIT_TX || phase_in == PH_WAIT_RX ||
                      phase_in == PH_WAIT_INTERVAL);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         poll_begin_ff     <= '0;
         interval_start_ff <= '0;
         poll_pending_ff   <= 1'b0;
         busy_ff           <= 1'b0;
         last_status_ff    <= ST_OK;
      end else if (s1_move) begin
         phase_ff          <= phase_in;
         poll_begin_ff     <= poll_begin_in;
         interval_start_ff <= interval_start_in;
         poll_pending_ff   <= poll_pending_in;
         busy_ff           <= busy_in;
         last_status_ff    <= last_status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_action_ff <= action_in;
         rsp_status_ff <= last_status_in;
         rsp_phase_ff  <= phase_in;
         rsp_cs_n_ff   <= cs_n_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action        = rsp_action_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_phase         = rsp_phase_ff;
   assign rsp_chip_select_n = rsp_cs_n_ff;

`ifndef SYNTHESIS
   // busy exactly while a transfer is under way
   a_busy_phase : assert property (@(posedge clock) disable iff (reset)
      busy_ff == (phase_ff == PH_WAIT_TX || phase_ff == PH_WAIT_RX ||
                  phase_ff == PH_WAIT_INTERVAL))
      else $error("busy flag out of step with phase");

   a_pending_phase : assert property (@(posedge clock) disable iff (reset)
      poll_pending_ff |-> phase_ff == PH_WAIT_INTERVAL)
      else $error("poll pending outside interval wait");

   // an idle start always opens a transfer in the next cycle
   a_start_opens : assert property (@(posedge clock) disable iff (reset)
      s1_move && s1_type_ff == REQ_START && !busy_ff |=>
         phase_ff == PH_WAIT_TX && rsp_valid_ff && rsp_action_ff == ACT_TX)
      else $error("start item did not open a transfer");

   // the request side stalls only behind a stalled result
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall && s1_valid_ff)
      else $error("request stalled without a held result");
`endif

endmodule
